@@ sv/rtb_pkg.sv @@
package rtb_pkg;

    // Fixed field widths of the command stream
    localparam int CMD_W       = 2;
    localparam int COORD_W     = 13;
    localparam int S_TDATA_W   = 32;
    localparam int S_TUSER_W   = CMD_W;
    localparam int M_TDATA_W   = 8;

    // Default sizing of the tracked universe
    localparam int POINTS_DEF    = 4096;
    localparam int WORD_BITS_DEF = 64;

    // Command codes carried in tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    // Finished item handed from the walker to the output stage
    typedef struct packed {
        logic valid;
        logic covered;
    } res_t;

endpackage

@@ sv/rtb_bitmap_mem.sv @@
module rtb_bitmap_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rtb_walker.sv @@
module rtb_walker #(
    parameter int POINTS    = rtb_pkg::POINTS_DEF,
    parameter int WORD_BITS = rtb_pkg::WORD_BITS_DEF,
    parameter int AW        = 6
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rtb_pkg::CMD_W-1:0]   in_cmd,
    input  logic [rtb_pkg::COORD_W-1:0] in_left,
    input  logic [rtb_pkg::COORD_W-1:0] in_right,
    input  logic                        out_ready,
    output rtb_pkg::res_t               res,
    output logic                        mem_re,
    output logic [AW-1:0]               mem_raddr,
    input  logic [WORD_BITS-1:0]        mem_rdata,
    output logic                        mem_we,
    output logic [AW-1:0]               mem_waddr,
    output logic [WORD_BITS-1:0]        mem_wdata
);

    import rtb_pkg::*;

    localparam int NWORDS = (POINTS + WORD_BITS - 1) / WORD_BITS;
    localparam int PBITS  = $clog2(POINTS + 1);
    localparam int PW     = ((PBITS > COORD_W) ? PBITS : COORD_W) + 1;
    localparam int SW     = $clog2(WORD_BITS);
    localparam logic [PW-1:0]        POINTS_PW = PW'(POINTS);
    localparam logic [PW-1:0]        WB_PW     = PW'(WORD_BITS);
    localparam logic [AW-1:0]        LAST_WORD = AW'(NWORDS - 1);
    localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [PW-1:0]         lo_reg, lo_next;
    logic [PW-1:0]         hi_reg, hi_next;
    logic [PW-1:0]         base_reg, base_next;
    logic [AW-1:0]         word_reg, word_next;
    logic                  covered_reg, covered_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic [AW-1:0]         wb_addr_reg, wb_addr_next;
    logic [WORD_BITS-1:0]  mask_reg, mask_next;

    logic [PW-1:0]         in_lo, in_hi, in_hi_clamp;
    logic                  in_walk, in_covered;
    logic                  issuing;
    logic [PW-1:0]         lo_off, hi_off;
    logic [WORD_BITS-1:0]  mask_lo, mask_hi;
    logic                  word_ok;

    // Decode a new command: clamp the interval and pick walk or direct answer
    always_comb begin
        in_lo       = PW'(in_left);
        in_hi       = PW'(in_right);
        in_hi_clamp = (in_hi > POINTS_PW) ? POINTS_PW : in_hi;
        in_walk     = 1'b0;
        in_covered  = 1'b0;
        case (in_cmd)
            CMD_ADD, CMD_REMOVE: begin
                in_walk = (in_lo < in_hi_clamp);
            end
            CMD_QUERY: begin
                in_covered = 1'b1;
                if (in_lo < in_hi) begin
                    if (in_hi > POINTS_PW) begin
                        in_covered = 1'b0;
                    end else begin
                        in_walk = 1'b1;
                    end
                end
            end
            default: begin
                in_walk    = 1'b0;
                in_covered = 1'b0;
            end
        endcase
    end

    // Mask of the interval's points within the word at base_reg
    always_comb begin
        issuing = (state_reg == ST_WALK) && (base_reg < hi_reg);
        lo_off  = (lo_reg > base_reg) ? (lo_reg - base_reg) : '0;
        hi_off  = hi_reg - base_reg;
        mask_lo = (lo_off >= WB_PW) ? '0 : (ONES << lo_off[SW-1:0]);
        mask_hi = (hi_off >= WB_PW) ? ONES : ~(ONES << hi_off[SW-1:0]);
        word_ok = ((mem_rdata & mask_reg) == mask_reg);
    end

    // Sequencer: clear sweep, command accept, word walk, result hand-off
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        base_next    = base_reg;
        word_next    = word_reg;
        covered_next = covered_reg;
        rd_pend_next = 1'b0;
        wb_addr_next = wb_addr_reg;
        mask_next    = mask_reg;
        in_ready     = (state_reg == ST_IDLE);
        res.valid    = 1'b0;
        res.covered  = covered_reg;
        mem_re       = 1'b0;
        mem_raddr    = word_reg;
        mem_we       = 1'b0;
        mem_waddr    = wb_addr_reg;
        mem_wdata    = '0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = word_reg;
                mem_wdata = '0;
                if (word_reg == LAST_WORD) begin
                    word_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    word_next = word_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    cmd_next     = cmd_t'(in_cmd);
                    lo_next      = in_lo;
                    hi_next      = in_hi_clamp;
                    base_next    = '0;
                    word_next    = '0;
                    covered_next = in_covered;
                    state_next   = in_walk ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                // Modify and write back the word read in the previous cycle
                if (rd_pend_reg) begin
                    if (cmd_reg == CMD_QUERY) begin
                        covered_next = covered_reg & word_ok;
                    end else begin
                        mem_we    = |mask_reg;
                        mem_wdata = (cmd_reg == CMD_ADD) ? (mem_rdata | mask_reg)
                                                         : (mem_rdata & ~mask_reg);
                    end
                end
                // Issue the read of the next word, or finish
                if (issuing) begin
                    mem_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    wb_addr_next = word_reg;
                    mask_next    = mask_lo & mask_hi;
                    word_next    = word_reg + AW'(1);
                    base_next    = base_reg + WB_PW;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_ready) begin
                    res.valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            word_reg    <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            word_reg    <= word_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        base_reg    <= base_next;
        covered_reg <= covered_next;
        wb_addr_reg <= wb_addr_next;
        mask_reg    <= mask_next;
    end

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !mem_we)
        else $error("bitmap written while idle");

    a_pend_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> state_reg == ST_WALK)
        else $error("read data pending outside a walk");

    a_no_same_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
        else $error("read and write of the same word in one cycle");

    a_accept_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg == ST_WALK || state_reg == ST_DONE))
        else $error("accepted command did not start");

    a_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |=> state_reg == ST_IDLE)
        else $error("walker did not return to idle after a result");

endmodule

@@ sv/range_tracking_bitmap_core.sv @@
// Flow: an accepted item either walks the bitmap from word 0 up to the word that holds point
// min(right, POINTS) - 1 or skips the walk; its result then goes to the register that drives m_tvalid.
// Throughput: one item at a time; the walk reads one bitmap word per cycle from word 0 and,
// for add and remove, writes it back modified, through the single read and single write port.
// Reset: aresetn is synchronous, active low; afterwards the bitmap is zeroed in a sweep over
// all ceil(POINTS / WORD_BITS) words (64 by default) during which s_tready stays low.
module range_tracking_bitmap_core #(
    parameter int POINTS    = rtb_pkg::POINTS_DEF,
    parameter int WORD_BITS = rtb_pkg::WORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rtb_pkg::S_TDATA_W-1:0] s_tdata,  // [12:0] left, [25:13] right
    input  logic [rtb_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] cmd
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rtb_pkg::M_TDATA_W-1:0] m_tdata   // [0] covered
);

    import rtb_pkg::*;

    localparam int NWORDS = (POINTS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    logic                 out_ready;
    res_t                 res;
    logic                 mem_re, mem_we;
    logic [AW-1:0]        mem_raddr, mem_waddr;
    logic [WORD_BITS-1:0] mem_rdata, mem_wdata;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 m_covered_reg, m_covered_next;

    rtb_bitmap_mem #(
        .DEPTH (NWORDS),
        .WIDTH (WORD_BITS),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rtb_walker #(
        .POINTS    (POINTS),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser[CMD_W-1:0]),
        .in_left   (s_tdata[COORD_W-1:0]),
        .in_right  (s_tdata[2*COORD_W-1:COORD_W]),
        .out_ready (out_ready),
        .res       (res),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    // Output register: load a finished result, drop it once the transfer completes
    always_comb begin
        out_ready      = !m_tvalid_reg || m_tready;
        m_tvalid_next  = m_tvalid_reg;
        m_covered_next = m_covered_reg;
        if (res.valid) begin
            m_tvalid_next  = 1'b1;
            m_covered_next = res.covered;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_covered_reg <= m_covered_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 1){1'b0}}, m_covered_reg};

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import rtb_pkg::*;

    localparam int POINTS    = POINTS_DEF;
    localparam int WORD_BITS = WORD_BITS_DEF;
    // Worst walk: the walk over every bitmap word
    localparam int WALK_CYCLES = 2 + (POINTS + WORD_BITS - 1) / WORD_BITS;
    localparam int RANDOM_ITEMS = 1500;
    // Command code outside the enum; the block must treat it as a no-op
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow bitmap and pending covered flags, oldest first
    logic [POINTS-1:0] tracked_points = '0;
    bit                expected_covered[$];
    int                mismatch_count = 0;

    // Sender burst state
    int burst_left = 0;
    int gap_max    = 0;

    // Most recent nonempty add, used to aim queries at covered ranges
    int last_add_lo = 0;
    int last_add_hi = 0;

    range_tracking_bitmap_core #(
        .POINTS    (POINTS),
        .WORD_BITS (WORD_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Update the shadow bitmap and return the covered flag for one command
    function automatic bit apply_range_command(input logic [CMD_W-1:0] cmd,
                                               input int lo, input int hi);
        int top;
        bit covered;
        covered = 1'b0;
        if (cmd == CMD_ADD || cmd == CMD_REMOVE) begin
            top = (hi > POINTS) ? POINTS : hi;
            for (int p = lo; p < top; p++)
                tracked_points[p] = (cmd == CMD_ADD);
        end else if (cmd == CMD_QUERY) begin
            covered = 1'b1;
            if (lo < hi) begin
                if (hi > POINTS) begin
                    covered = 1'b0;
                end else begin
                    for (int p = lo; p < hi; p++) begin
                        if (!tracked_points[p])
                            covered = 1'b0;
                    end
                end
            end
        end
        return covered;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] %s", $time, what);
    endtask

    // Drive one command and hold it until the block takes the transfer
    task automatic send_item(input logic [CMD_W-1:0] cmd, input int lo, input int hi);
        int gap;
        bit want_covered;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = S_TDATA_W'({hi[COORD_W-1:0], lo[COORD_W-1:0]});
        do @(posedge aclk); while (!s_tready);
        want_covered = apply_range_command(cmd, lo, hi);
        expected_covered = {expected_covered, want_covered};
    endtask

    // Idle the sender until every expected result has come back
    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (expected_covered.size() != 0)
            @(negedge aclk);
    endtask

    task automatic test_full_universe();
        send_item(CMD_QUERY, 0, 0);
        send_item(CMD_QUERY, 0, 1);
        send_item(CMD_ADD, 0, POINTS);
        send_item(CMD_QUERY, 0, POINTS);
        send_item(CMD_QUERY, POINTS - 1, POINTS);
        send_item(CMD_REMOVE, 0, POINTS);
        send_item(CMD_QUERY, 0, POINTS);
        wait_for_results();
    endtask

    task automatic test_word_boundaries();
        send_item(CMD_ADD, WORD_BITS - 1, WORD_BITS + 1);
        send_item(CMD_QUERY, WORD_BITS - 1, WORD_BITS + 1);
        send_item(CMD_QUERY, WORD_BITS - 2, WORD_BITS + 1);
        send_item(CMD_QUERY, WORD_BITS, WORD_BITS + 1);
        send_item(CMD_ADD, POINTS - 1, POINTS);
        send_item(CMD_QUERY, POINTS - WORD_BITS, POINTS);
        send_item(CMD_QUERY, POINTS - 1, POINTS);
        send_item(CMD_REMOVE, WORD_BITS, POINTS);
        send_item(CMD_QUERY, WORD_BITS - 1, WORD_BITS);
        wait_for_results();
    endtask

    task automatic test_empty_and_unused();
        send_item(CMD_ADD, 200, 100);
        send_item(CMD_QUERY, 100, 200);
        send_item(CMD_REMOVE, WORD_BITS - 1, WORD_BITS - 1);
        send_item(CMD_QUERY, WORD_BITS - 1, WORD_BITS);
        send_item(CMD_UNUSED, 0, POINTS);
        send_item(CMD_QUERY, WORD_BITS - 1, WORD_BITS);
        send_item(CMD_QUERY, POINTS, POINTS);
        send_item(CMD_QUERY, POINTS, 0);
        send_item(CMD_ADD, POINTS, POINTS);
        wait_for_results();
    endtask

    // Pick an interval: mostly short spans, some word-aligned, some wild or at the ends
    task automatic pick_interval(output int lo, output int hi);
        int shape;
        shape = $urandom_range(0, 99);
        if (shape < 40) begin
            lo = $urandom_range(0, POINTS - 1);
            hi = lo + $urandom_range(0, 80);
        end else if (shape < 55) begin
            lo = $urandom_range(0, POINTS / WORD_BITS) * WORD_BITS - $urandom_range(0, 1);
            hi = lo + $urandom_range(1, 2 * WORD_BITS + 2);
        end else if (shape < 70) begin
            lo = $urandom_range(0, POINTS);
            hi = $urandom_range(0, POINTS);
        end else if (shape < 80) begin
            lo = $urandom_range(POINTS - 200, POINTS);
            hi = POINTS;
        end else begin
            lo = $urandom_range(0, 8);
            hi = $urandom_range(0, 200);
        end
        if (lo < 0) lo = 0;
        if (hi > POINTS) hi = POINTS;
    endtask

    task automatic test_random_traffic();
        int pick;
        int lo;
        int hi;
        logic [CMD_W-1:0] cmd;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Change the sender's pace now and then, including stretches with no gaps
            if (n % 60 == 0) begin
                case ($urandom_range(0, 3))
                    0: gap_max = 0;
                    1: gap_max = 2;
                    2: gap_max = 8;
                    default: gap_max = 30;
                endcase
            end
            // Let the block run dry twice mid-stream
            if (n > 0 && n % 500 == 0)
                wait_for_results();
            pick = $urandom_range(0, 99);
            if (pick < 35)      cmd = CMD_ADD;
            else if (pick < 55) cmd = CMD_REMOVE;
            else if (pick < 99) cmd = CMD_QUERY;
            else                cmd = CMD_UNUSED;
            pick_interval(lo, hi);
            // Aim half the queries inside the last added range so hits are common
            if (cmd == CMD_QUERY && last_add_lo < last_add_hi && $urandom_range(0, 1)) begin
                lo = $urandom_range(last_add_lo, last_add_hi - 1);
                hi = $urandom_range(lo + 1, last_add_hi);
            end
            if (cmd == CMD_ADD && lo < hi) begin
                last_add_lo = lo;
                last_add_hi = hi;
            end
            send_item(cmd, lo, hi);
        end
        wait_for_results();
    endtask

    // Receiver backpressure: stretches of always-ready, light, heavy and long stalls
    initial begin
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = ($urandom_range(0, 3) != 0);
                    2: m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    // Compare each result transfer with the oldest expected flag
    always @(posedge aclk) begin
        bit want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_covered.size() == 0) begin
                report_mismatch($sformatf("unexpected result, covered=%0b", m_tdata[0]));
            end else begin
                want = expected_covered.pop_front();
                if (m_tdata[0] !== want)
                    report_mismatch($sformatf("covered: got %0b, expected %0b",
                                              m_tdata[0], want));
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_full_universe();
        test_word_boundaries();
        test_empty_and_unused();
        test_random_traffic();
        repeat (WALK_CYCLES + 30) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
